/* rtl/core/gwss_pkg.sv */
`default_nettype none
package gwss_pkg;

	localparam int SAMPLE_W   = 14;
	localparam int START_W    = 12;
	localparam int GATE_W     = 11;
	localparam int RLEN_W     = 13;
	localparam int EVCNT_W    = 11;
	localparam int IDX_W      = 12;
	localparam int REC_W      = 10;
	localparam int ACC_W      = 24;
	localparam int SUM_W      = 34;
	localparam int SQ_W       = 47;
	localparam int TSQ_W      = 57;
	localparam int PROD_W     = 68;
	localparam int VAR_SHIFT  = 16;
	localparam int MEAN_SHIFT = 8;
	localparam int DIVD_W     = PROD_W + VAR_SHIFT;
	localparam int DIVS_W     = 20;
	localparam int QUO_W      = 64;
	localparam int STAT_W     = 32;
	localparam int CHUNK_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FIFO_DEPTH = 4;

	localparam int MAX_RECORD = 4096;
	localparam int MAX_EVENTS = 1024;
	localparam int MIN_EVENTS = 2;

	localparam int GATE_RST  = 150;
	localparam int RLEN_RST  = 2692;
	localparam int EVCNT_RST = 1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE_LENGTH   = 2'd0,
		REG_RECORD_LENGTH = 2'd1,
		REG_EVENT_COUNT   = 2'd2
	} cfg_reg_t;

	// effective settings seen by the datapath (record length and event count clamped)
	typedef struct packed {
		logic [GATE_W-1:0]  gate_length;
		logic [RLEN_W-1:0]  record_length;
		logic [EVCNT_W-1:0] event_count;
	} cfg_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] event_sum;
		logic [REC_W-1:0]        event_number;
		logic                    last;
	} rec_t;

	function automatic logic [RLEN_W-1:0] rec_len_eff(input logic [RLEN_W-1:0] v);
		logic [RLEN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = RLEN_W'(1);
		end else if (v > RLEN_W'(MAX_RECORD)) begin
			r = RLEN_W'(MAX_RECORD);
		end
		return r;
	endfunction

	function automatic logic [EVCNT_W-1:0] ev_cnt_eff(input logic [EVCNT_W-1:0] v);
		logic [EVCNT_W-1:0] r;
		r = v;
		if (v < EVCNT_W'(MIN_EVENTS)) begin
			r = EVCNT_W'(MIN_EVENTS);
		end else if (v > EVCNT_W'(MAX_EVENTS)) begin
			r = EVCNT_W'(MAX_EVENTS);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/gwss_in_if.sv */
`default_nettype none
interface gwss_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [gwss_pkg::SAMPLE_W-1:0]  sample;
	logic [gwss_pkg::START_W-1:0]          window_start;

	modport source(output valid, sample, window_start, input ready);
	modport sink(input valid, sample, window_start, output ready);
endinterface
`default_nettype wire

/* rtl/core/gwss_out_if.sv */
`default_nettype none
interface gwss_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [gwss_pkg::ACC_W-1:0]    event_sum;
	logic [gwss_pkg::REC_W-1:0]           event_number;
	logic                                 stats_valid;
	logic signed [gwss_pkg::STAT_W-1:0]   mean_q8;
	logic [gwss_pkg::STAT_W-1:0]          stddev_q8;

	modport source(output valid, event_sum, event_number, stats_valid, mean_q8, stddev_q8,
		input ready);
	modport sink(input valid, event_sum, event_number, stats_valid, mean_q8, stddev_q8,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/gwss_front.sv */
`default_nettype none
module gwss_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gwss_pkg::cfg_t cfg,
	gwss_in_if.sink             smp,
	output gwss_pkg::rec_t      push_data,
	output logic                push_valid,
	input  wire logic           push_ready
);

	localparam int SW = gwss_pkg::ACC_W + 1;
	localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (gwss_pkg::ACC_W - 1)) - 1);
	localparam logic signed [SW-1:0] SAT_LO = -SW'(2 ** (gwss_pkg::ACC_W - 1));

	logic [gwss_pkg::IDX_W-1:0]          idx_q;
	logic [gwss_pkg::START_W-1:0]        start_q;
	logic signed [gwss_pkg::ACC_W-1:0]   acc_q;
	logic [gwss_pkg::REC_W-1:0]          rec_q;

	logic                                accept;
	logic [gwss_pkg::START_W-1:0]        start_eff;
	logic                                in_gate;
	logic signed [SW-1:0]                sum;
	logic signed [gwss_pkg::ACC_W-1:0]   sat;
	logic signed [gwss_pkg::ACC_W-1:0]   acc_next;
	logic                                rec_end;
	logic                                last;

	assign smp.ready = push_ready;
	assign accept    = smp.valid && push_ready;

	always_comb begin
		start_eff = (idx_q == '0) ? smp.window_start : start_q;
		in_gate   = (idx_q >= start_eff) &&
			((idx_q - start_eff) < gwss_pkg::IDX_W'(cfg.gate_length));
		sum = SW'(acc_q) + SW'(smp.sample);
		if (sum > SAT_HI) begin
			sat = SAT_HI[gwss_pkg::ACC_W-1:0];
		end else if (sum < SAT_LO) begin
			sat = SAT_LO[gwss_pkg::ACC_W-1:0];
		end else begin
			sat = sum[gwss_pkg::ACC_W-1:0];
		end
		acc_next = in_gate ? sat : acc_q;
		rec_end  = (gwss_pkg::RLEN_W'(idx_q) + gwss_pkg::RLEN_W'(1)) >= cfg.record_length;
		last     = (gwss_pkg::EVCNT_W'(rec_q) + gwss_pkg::EVCNT_W'(1)) >= cfg.event_count;
	end

	assign push_valid             = accept && rec_end;
	assign push_data.event_sum    = acc_next;
	assign push_data.event_number = rec_q;
	assign push_data.last         = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			start_q <= '0;
			acc_q   <= '0;
			rec_q   <= '0;
		end else if (accept) begin
			start_q <= start_eff;
			if (rec_end) begin
				idx_q <= '0;
				acc_q <= '0;
				rec_q <= last ? '0 : rec_q + gwss_pkg::REC_W'(1);
			end else begin
				idx_q <= idx_q + gwss_pkg::IDX_W'(1);
				acc_q <= acc_next;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/gwss_fifo.sv */
`default_nettype none
module gwss_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gwss_pkg::rec_t push_data,
	input  wire logic           push_valid,
	output logic                push_ready,
	output gwss_pkg::rec_t      pop_data,
	output logic                pop_valid,
	input  wire logic           pop_ready
);

	localparam int PTR_W = $clog2(gwss_pkg::FIFO_DEPTH);

	gwss_pkg::rec_t     slot_q [gwss_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = cnt_q != (PTR_W + 1)'(gwss_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/gwss_div.sv */
`default_nettype none
module gwss_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [gwss_pkg::DIVD_W-1:0]  dividend,
	input  wire logic [gwss_pkg::DIVS_W-1:0]  divisor,
	output logic                              done,
	output logic [gwss_pkg::QUO_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(gwss_pkg::DIVD_W);
	localparam int TW    = gwss_pkg::DIVS_W + 1;

	logic [gwss_pkg::DIVD_W-1:0]  quo_q;
	logic [gwss_pkg::DIVS_W-1:0]  rem_q;
	logic [gwss_pkg::DIVS_W-1:0]  dsr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [TW-1:0]                trial;
	logic                         fits;

	assign trial = {rem_q, quo_q[gwss_pkg::DIVD_W-1]};
	assign fits  = trial >= TW'(dsr_q);

	// restoring division, one quotient bit a cycle; saturates to the output width
	assign quotient = (|quo_q[gwss_pkg::DIVD_W-1:gwss_pkg::QUO_W]) ? '1 :
		quo_q[gwss_pkg::QUO_W-1:0];
	assign done = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[gwss_pkg::DIVD_W-2:0], fits};
			rem_q <= fits ? gwss_pkg::DIVS_W'(trial - TW'(dsr_q)) : trial[gwss_pkg::DIVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(gwss_pkg::DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/gwss_sqrt.sv */
`default_nettype none
module gwss_sqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [gwss_pkg::QUO_W-1:0]  radicand,
	output logic                             done,
	output logic [gwss_pkg::STAT_W-1:0]      root
);

	localparam int W = gwss_pkg::QUO_W;

	logic [W-1:0]  x_q;
	logic [W-1:0]  res_q;
	logic [W-1:0]  bit_q;
	logic          busy_q;
	logic          done_q;
	logic [W-1:0]  trial;
	logic          fits;

	assign trial = res_q + bit_q;
	assign fits  = x_q >= trial;
	assign root  = res_q[gwss_pkg::STAT_W-1:0];
	assign done  = done_q;

	// digit-by-digit root, one result bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (fits) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/gwss_back.sv */
`default_nettype none
module gwss_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [gwss_pkg::EVCNT_W-1:0]  event_count,
	input  wire gwss_pkg::rec_t                pop_data,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	gwss_out_if.source                         res
);

	localparam int CW = gwss_pkg::CHUNK_W;
	localparam int NW = gwss_pkg::EVCNT_W;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'h0001,
		ST_SQ    = 14'h0002,
		ST_ADD   = 14'h0004,
		ST_SMAG  = 14'h0008,
		ST_MGO   = 14'h0010,
		ST_MWAIT = 14'h0020,
		ST_MUL   = 14'h0040,
		ST_MACC  = 14'h0080,
		ST_DIFF  = 14'h0100,
		ST_VGO   = 14'h0200,
		ST_VWAIT = 14'h0400,
		ST_RGO   = 14'h0800,
		ST_RWAIT = 14'h1000,
		ST_EMIT  = 14'h2000
	} state_t;

	typedef enum logic [5:0] {
		MS_NQ_LO = 6'b000001,
		MS_NQ_HI = 6'b000010,
		MS_SS_LL = 6'b000100,
		MS_SS_LH = 6'b001000,
		MS_SS_HL = 6'b010000,
		MS_SS_HH = 6'b100000
	} mul_step_t;

	state_t                               state_q;
	mul_step_t                            step_q;
	gwss_pkg::rec_t                       ent_q;
	logic [gwss_pkg::SQ_W-1:0]            sq_q;
	logic signed [gwss_pkg::SUM_W-1:0]    tot_s_q;
	logic [gwss_pkg::TSQ_W-1:0]           tot_q_q;
	logic                                 neg_q;
	logic [gwss_pkg::SUM_W-1:0]           smag_q;
	logic [gwss_pkg::STAT_W-1:0]          mean_q;
	logic [2*CW-1:0]                      pp_q;
	logic [gwss_pkg::PROD_W-1:0]          nq_q;
	logic [gwss_pkg::PROD_W-1:0]          ss_q;
	logic [gwss_pkg::PROD_W-1:0]          d_q;
	logic [gwss_pkg::DIVS_W-1:0]          nn_q;
	logic [gwss_pkg::QUO_W-1:0]           var_q;

	logic                                 res_valid_q;
	logic signed [gwss_pkg::ACC_W-1:0]    res_sum_q;
	logic [gwss_pkg::REC_W-1:0]           res_num_q;
	logic                                 res_stat_q;
	logic [gwss_pkg::STAT_W-1:0]          res_mean_q;
	logic [gwss_pkg::STAT_W-1:0]          res_sd_q;

	logic [gwss_pkg::ACC_W-1:0]           mag;
	logic [2*gwss_pkg::ACC_W-1:0]         mag_sq;
	logic [CW-1:0]                        mul_a;
	logic [CW-1:0]                        mul_b;
	logic [2*NW-1:0]                      nn_full;
	logic                                 div_start;
	logic [gwss_pkg::DIVD_W-1:0]          div_dividend;
	logic [gwss_pkg::DIVS_W-1:0]          div_divisor;
	logic                                 div_done;
	logic [gwss_pkg::QUO_W-1:0]           div_quo;
	logic                                 sqrt_start;
	logic                                 sqrt_done;
	logic [gwss_pkg::STAT_W-1:0]          sqrt_root;
	logic                                 load_out;

	assign pop_ready = state_q == ST_IDLE;
	assign load_out  = (state_q == ST_EMIT) && (!res_valid_q || res.ready);

	assign mag     = ent_q.event_sum[gwss_pkg::ACC_W-1] ? gwss_pkg::ACC_W'(-ent_q.event_sum) :
		gwss_pkg::ACC_W'(ent_q.event_sum);
	assign mag_sq  = mag * mag;
	assign nn_full = event_count * (event_count - NW'(1));

	always_comb begin
		unique case (step_q)
			MS_NQ_LO: begin
				mul_a = tot_q_q[CW-1:0];
				mul_b = CW'(event_count);
			end
			MS_NQ_HI: begin
				mul_a = CW'(tot_q_q[gwss_pkg::TSQ_W-1:CW]);
				mul_b = CW'(event_count);
			end
			MS_SS_LL: begin
				mul_a = smag_q[CW-1:0];
				mul_b = smag_q[CW-1:0];
			end
			MS_SS_LH: begin
				mul_a = smag_q[CW-1:0];
				mul_b = CW'(smag_q[gwss_pkg::SUM_W-1:CW]);
			end
			MS_SS_HL: begin
				mul_a = CW'(smag_q[gwss_pkg::SUM_W-1:CW]);
				mul_b = smag_q[CW-1:0];
			end
			MS_SS_HH: begin
				mul_a = CW'(smag_q[gwss_pkg::SUM_W-1:CW]);
				mul_b = CW'(smag_q[gwss_pkg::SUM_W-1:CW]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// the divider serves both the mean and the variance
	always_comb begin
		div_start    = (state_q == ST_MGO) || (state_q == ST_VGO);
		div_dividend = {d_q, {gwss_pkg::VAR_SHIFT{1'b0}}};
		div_divisor  = nn_q;
		if (state_q == ST_MGO) begin
			div_dividend = gwss_pkg::DIVD_W'({smag_q, {gwss_pkg::MEAN_SHIFT{1'b0}}}) +
				(neg_q ? gwss_pkg::DIVD_W'(event_count - NW'(1)) : '0);
			div_divisor  = gwss_pkg::DIVS_W'(event_count);
		end
	end

	assign sqrt_start = state_q == ST_RGO;

	gwss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	gwss_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (var_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			ent_q <= pop_data;
		end
		if (state_q == ST_SQ) begin
			sq_q <= mag_sq[gwss_pkg::SQ_W-1:0];
		end
		if (state_q == ST_SMAG) begin
			neg_q  <= tot_s_q[gwss_pkg::SUM_W-1];
			smag_q <= tot_s_q[gwss_pkg::SUM_W-1] ? gwss_pkg::SUM_W'(-tot_s_q) :
				gwss_pkg::SUM_W'(tot_s_q);
		end
		if (state_q == ST_MWAIT && div_done) begin
			mean_q <= neg_q ? (gwss_pkg::STAT_W'(0) - div_quo[gwss_pkg::STAT_W-1:0]) :
				div_quo[gwss_pkg::STAT_W-1:0];
		end
		if (state_q == ST_MUL) begin
			pp_q <= mul_a * mul_b;
		end
		if (state_q == ST_DIFF) begin
			d_q  <= (nq_q >= ss_q) ? nq_q - ss_q : '0;
			nn_q <= nn_full[gwss_pkg::DIVS_W-1:0];
		end
		if (state_q == ST_VWAIT && div_done) begin
			var_q <= div_quo;
		end
		if (load_out) begin
			res_sum_q  <= ent_q.event_sum;
			res_num_q  <= ent_q.event_number;
			res_stat_q <= ent_q.last;
			res_mean_q <= ent_q.last ? mean_q : '0;
			res_sd_q   <= ent_q.last ? sqrt_root : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= MS_NQ_LO;
			tot_s_q     <= '0;
			tot_q_q     <= '0;
			nq_q        <= '0;
			ss_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					tot_s_q <= tot_s_q + gwss_pkg::SUM_W'(ent_q.event_sum);
					tot_q_q <= tot_q_q + gwss_pkg::TSQ_W'(sq_q);
					state_q <= ent_q.last ? ST_SMAG : ST_EMIT;
				end
				ST_SMAG: begin
					nq_q    <= '0;
					ss_q    <= '0;
					step_q  <= MS_NQ_LO;
					state_q <= ST_MGO;
				end
				ST_MGO: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_MACC;
				end
				ST_MACC: begin
					state_q <= ST_MUL;
					unique case (step_q)
						MS_NQ_LO: begin
							nq_q   <= nq_q + gwss_pkg::PROD_W'(pp_q);
							step_q <= MS_NQ_HI;
						end
						MS_NQ_HI: begin
							nq_q   <= nq_q + (gwss_pkg::PROD_W'(pp_q) << CW);
							step_q <= MS_SS_LL;
						end
						MS_SS_LL: begin
							ss_q   <= ss_q + gwss_pkg::PROD_W'(pp_q);
							step_q <= MS_SS_LH;
						end
						MS_SS_LH: begin
							ss_q   <= ss_q + (gwss_pkg::PROD_W'(pp_q) << CW);
							step_q <= MS_SS_HL;
						end
						MS_SS_HL: begin
							ss_q   <= ss_q + (gwss_pkg::PROD_W'(pp_q) << CW);
							step_q <= MS_SS_HH;
						end
						MS_SS_HH: begin
							ss_q    <= ss_q + (gwss_pkg::PROD_W'(pp_q) << (2 * CW));
							step_q  <= MS_NQ_LO;
							state_q <= ST_DIFF;
						end
						default: begin
							step_q  <= MS_NQ_LO;
							state_q <= ST_DIFF;
						end
					endcase
				end
				ST_DIFF: begin
					state_q <= ST_VGO;
				end
				ST_VGO: begin
					state_q <= ST_VWAIT;
				end
				ST_VWAIT: begin
					if (div_done) begin
						state_q <= ST_RGO;
					end
				end
				ST_RGO: begin
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					if (sqrt_done) begin
						tot_s_q <= '0;
						tot_q_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid        = res_valid_q;
	assign res.event_sum    = res_sum_q;
	assign res.event_number = res_num_q;
	assign res.stats_valid  = res_stat_q;
	assign res.mean_q8      = res_mean_q;
	assign res.stddev_q8    = res_sd_q;

endmodule
`default_nettype wire

/* rtl/core/gated_window_sum_statistics.sv */
// Samples: one beat a cycle while the record queue has room; the gated sum is built as samples arrive.
// Results: a record's sum passes the queue and the back end's square, add and emit states before it is
//   registered; the last record of a set also runs two 84-step divisions and a 32-step root, 6 multiplies.
// Records: the back end takes a new record only once the last is emitted; a 4-deep queue absorbs short records.
// Reset (arst_n low): counters, totals and queue cleared, registers to 150/2692/1000.
`default_nettype none
module gated_window_sum_statistics (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [gwss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gwss_pkg::CFG_DATA_W-1:0]  cfg_data,
	gwss_in_if.sink                               samples,
	gwss_out_if.source                            results
);

	logic [gwss_pkg::GATE_W-1:0]   gate_q;
	logic [gwss_pkg::RLEN_W-1:0]   rlen_q;
	logic [gwss_pkg::EVCNT_W-1:0]  evcnt_q;

	gwss_pkg::cfg_t  cfg;
	gwss_pkg::rec_t  push_data;
	gwss_pkg::rec_t  pop_data;
	logic            push_valid;
	logic            push_ready;
	logic            pop_valid;
	logic            pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q  <= gwss_pkg::GATE_W'(gwss_pkg::GATE_RST);
			rlen_q  <= gwss_pkg::RLEN_W'(gwss_pkg::RLEN_RST);
			evcnt_q <= gwss_pkg::EVCNT_W'(gwss_pkg::EVCNT_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gwss_pkg::REG_GATE_LENGTH: begin
					gate_q <= cfg_data[gwss_pkg::GATE_W-1:0];
				end
				gwss_pkg::REG_RECORD_LENGTH: begin
					rlen_q <= cfg_data[gwss_pkg::RLEN_W-1:0];
				end
				gwss_pkg::REG_EVENT_COUNT: begin
					evcnt_q <= cfg_data[gwss_pkg::EVCNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.gate_length   = gate_q;
	assign cfg.record_length = gwss_pkg::rec_len_eff(rlen_q);
	assign cfg.event_count   = gwss_pkg::ev_cnt_eff(evcnt_q);

	gwss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.smp        (samples),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	gwss_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	gwss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_count (cfg.event_count),
		.pop_data    (pop_data),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.res         (results)
	);

endmodule
`default_nettype wire

/* verif/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gwss_pkg::*;

	localparam int QUIET_CYCLES  = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 30;
	localparam int SAMPLE_MAX    = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN    = -(1 << (SAMPLE_W - 1));
	localparam int ACC_MAX       = (1 << (ACC_W - 1)) - 1;
	localparam int ACC_MIN       = -(1 << (ACC_W - 1));
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [START_W-1:0]         window_start;
	} sample_beat_t;

	typedef struct packed {
		logic signed [ACC_W-1:0]  event_sum;
		logic [REC_W-1:0]         event_number;
		logic                     stats_valid;
		logic signed [STAT_W-1:0] mean_q8;
		logic [STAT_W-1:0]        stddev_q8;
	} record_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gwss_in_if  samples_if();
	gwss_out_if results_if();

	gated_window_sum_statistics u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if.sink),
		.results   (results_if.source)
	);

	// register copies and integrator state, all at their reset values
	logic [GATE_W-1:0]       gate_len_reg = GATE_W'(GATE_RST);
	logic [RLEN_W-1:0]       rec_len_reg = RLEN_W'(RLEN_RST);
	logic [EVCNT_W-1:0]      ev_cnt_reg = EVCNT_W'(EVCNT_RST);
	logic [IDX_W-1:0]        sample_pos = '0;
	logic [REC_W-1:0]        record_pos = '0;
	logic [START_W-1:0]      gate_start = '0;
	logic signed [ACC_W-1:0] window_sum = '0;
	logic signed [SUM_W-1:0] set_sum_total = '0;
	logic [TSQ_W-1:0]        set_square_total = '0;

	sample_beat_t   offered_samples[$];
	record_result_t expected_records[$];

	int   errors = 0;
	int   sender_idle_pct = 0;
	int   sink_stall_pct = 0;
	int   hold_left = 0;
	logic hold_start = 1'b0;
	int   cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int effective_record_length();
		int r;
		r = rec_len_reg;
		if (r < 1) begin
			r = 1;
		end else if (r > MAX_RECORD) begin
			r = MAX_RECORD;
		end
		return r;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] value);
		logic [63:0] rest, root, probe;
		rest = value;
		root = '0;
		probe = 64'd1 << 62;
		while (probe > rest) begin
			probe = probe >> 2;
		end
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic void integrate_sample(input logic signed [SAMPLE_W-1:0] s,
		input logic [START_W-1:0] ws);
		int             rl, n, p, gs, acc;
		longint         total, mag;
		logic [63:0]    smag, mean_raw, var_q16;
		logic [127:0]   scaled_sq, sq_of_sum, spread, quotient;
		record_result_t rec;
		rl = effective_record_length();
		n = ev_cnt_reg;
		if (n < MIN_EVENTS) begin
			n = MIN_EVENTS;
		end else if (n > MAX_EVENTS) begin
			n = MAX_EVENTS;
		end
		p = sample_pos;
		if (p == 0) begin
			gate_start = ws;
		end
		gs = gate_start;
		if (p >= gs && p - gs < int'(gate_len_reg)) begin
			acc = int'(window_sum) + int'(s);
			if (acc > ACC_MAX) begin
				acc = ACC_MAX;
			end else if (acc < ACC_MIN) begin
				acc = ACC_MIN;
			end
			window_sum = ACC_W'(acc);
		end
		if (p + 1 < rl) begin
			sample_pos = IDX_W'(p + 1);
			return;
		end

		mag = (window_sum < 0) ? -longint'(window_sum) : longint'(window_sum);
		set_sum_total = set_sum_total + window_sum;
		set_square_total = set_square_total + TSQ_W'(mag * mag);
		rec = '0;
		rec.event_sum = window_sum;
		rec.event_number = record_pos;
		if (int'(record_pos) + 1 >= n) begin
			total = longint'(set_sum_total);
			smag = (total < 0) ? 64'(-total) : 64'(total);
			scaled_sq = 128'(set_square_total) * 128'(n);
			sq_of_sum = 128'(smag) * 128'(smag);
			if (total >= 0) begin
				mean_raw = (smag * 64'd256) / 64'(n);
			end else begin
				mean_raw = -((smag * 64'd256 + 64'(n) - 64'd1) / 64'(n));
			end
			spread = (scaled_sq < sq_of_sum) ? '0 : scaled_sq - sq_of_sum;
			spread = spread << VAR_SHIFT;
			quotient = spread / 128'(n * (n - 1));
			var_q16 = (quotient[127:64] != 0) ? '1 : quotient[63:0];
			var_q16 = floor_sqrt(var_q16);
			rec.stats_valid = 1'b1;
			rec.mean_q8 = mean_raw[STAT_W-1:0];
			rec.stddev_q8 = var_q16[STAT_W-1:0];
			record_pos = '0;
			set_sum_total = '0;
			set_square_total = '0;
		end else begin
			record_pos = record_pos + 1'b1;
		end
		window_sum = '0;
		sample_pos = '0;
		expected_records.push_back(rec);
	endfunction

	function automatic void compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// sample driver: a beat stays offered until it is taken
	always @(posedge clk) begin : drive_samples
		sample_beat_t beat;
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
		end else if (!samples_if.valid || samples_if.ready) begin
			if (offered_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				beat = offered_samples.pop_front();
				samples_if.valid <= 1'b1;
				samples_if.sample <= beat.sample;
				samples_if.window_start <= beat.window_start;
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_start) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : check_records
		record_result_t want;
		if (arst_n && samples_if.valid && samples_if.ready) begin
			integrate_sample(samples_if.sample, samples_if.window_start);
		end
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_records.size() == 0) begin
				$display("%0t ns: event_sum expected no beat, actual %0d", $time,
					results_if.event_sum);
				errors++;
			end else begin
				want = expected_records.pop_front();
				compare_field("event_sum", want.event_sum, results_if.event_sum);
				compare_field("event_number", want.event_number, results_if.event_number);
				compare_field("stats_valid", want.stats_valid, results_if.stats_valid);
				compare_field("mean_q8", want.mean_q8, results_if.mean_q8);
				compare_field("stddev_q8", want.stddev_q8, results_if.stddev_q8);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_GATE_LENGTH: begin
				gate_len_reg = data[GATE_W-1:0];
			end
			REG_RECORD_LENGTH: begin
				rec_len_reg = data[RLEN_W-1:0];
			end
			REG_EVENT_COUNT: begin
				ev_cnt_reg = data[EVCNT_W-1:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic begin_phase(input idle_mode_t mode);
		@(negedge clk);
		sender_idle_pct = (mode == IDLE_SENDER) ? 50 : (mode == IDLE_BOTH) ? 32 : 0;
		sink_stall_pct = (mode == IDLE_SINK) ? 50 : (mode == IDLE_BOTH) ? 32 : 0;
	endtask

	task automatic drain_and_pause();
		do begin
			@(posedge clk);
		end while (offered_samples.size() != 0 || samples_if.valid
			|| expected_records.size() != 0 || hold_left != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	function automatic void queue_sample(input int s, input int ws);
		sample_beat_t beat;
		beat.sample = SAMPLE_W'(s);
		beat.window_start = START_W'(ws);
		offered_samples.push_back(beat);
	endfunction

	function automatic int pick_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			default: return int'($urandom);
		endcase
	endfunction

	function automatic int pick_start();
		if ($urandom_range(0, 3) == 0) begin
			return $urandom_range(0, (1 << START_W) - 1);
		end
		return $urandom_range(0, effective_record_length() + 1);
	endfunction

	function automatic void offer_random(input int count);
		for (int i = 0; i < count; i++) begin
			queue_sample(pick_sample(), pick_start());
		end
	endfunction

	task automatic random_settings();
		int g, r, e;
		case ($urandom_range(0, 9))
			0: g = 0;
			1: g = $urandom_range(1025, 2047);
			2: g = 1024;
			default: g = $urandom_range(1, 20);
		endcase
		case ($urandom_range(0, 19))
			0: r = 0;
			1: r = $urandom_range(25, 200);
			2: r = $urandom_range(4097, 8191);
			default: r = $urandom_range(1, 24);
		endcase
		case ($urandom_range(0, 9))
			0: e = $urandom_range(0, 1);
			1: e = $urandom_range(1025, 2047);
			2: e = $urandom_range(13, 60);
			default: e = $urandom_range(2, 12);
		endcase
		write_reg(REG_GATE_LENGTH, g);
		write_reg(REG_RECORD_LENGTH, r);
		write_reg(REG_EVENT_COUNT, e);
	endtask

	initial begin : stimulus
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		samples_if.window_start = '0;
		results_if.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: gate of 150 from the start of a long record
		begin_phase(IDLE_NONE);
		for (int i = 0; i < 150; i++) begin
			queue_sample(pick_sample(), (i == 0) ? 0 : $urandom_range(0, 4095));
		end
		drain_and_pause();

		// shorter record closes the open one on the next beat
		write_reg(REG_RECORD_LENGTH, 4);
		write_reg(REG_GATE_LENGTH, 2);
		write_reg(REG_EVENT_COUNT, 0);
		write_reg(REG_SPARE, 1);
		begin_phase(IDLE_NONE);
		queue_sample(5, 0);
		queue_sample(SAMPLE_MAX, 1);
		queue_sample(SAMPLE_MAX, 0);
		queue_sample(SAMPLE_MAX, 4095);
		queue_sample(SAMPLE_MIN, 0);
		for (int i = 0; i < 4; i++) begin
			queue_sample(SAMPLE_MIN, (i == 0) ? 3 : 0);
		end
		for (int i = 0; i < 4; i++) begin
			queue_sample(SAMPLE_MAX, 4095);
		end
		queue_sample(0, 2);
		queue_sample(0, 0);
		queue_sample(-1, 0);
		queue_sample(-1, 0);
		drain_and_pause();

		write_reg(REG_GATE_LENGTH, 0);
		write_reg(REG_RECORD_LENGTH, 0);
		write_reg(REG_EVENT_COUNT, 1);
		begin_phase(IDLE_NONE);
		queue_sample(SAMPLE_MAX, 0);
		queue_sample(SAMPLE_MIN, 0);
		queue_sample(SAMPLE_MAX, 4095);
		queue_sample(-1, 2048);
		drain_and_pause();

		// window sum driven past its negative limit, then a one-beat record ends the set
		write_reg(REG_GATE_LENGTH, 2047);
		write_reg(REG_RECORD_LENGTH, 1026);
		write_reg(REG_EVENT_COUNT, 2);
		begin_phase(IDLE_BOTH);
		for (int i = 0; i < 1026; i++) begin
			queue_sample(SAMPLE_MIN, 0);
		end
		drain_and_pause();
		write_reg(REG_RECORD_LENGTH, 1);
		begin_phase(IDLE_NONE);
		queue_sample(SAMPLE_MAX, 0);
		drain_and_pause();

		// clamped record length and event count, then both lowered mid-way
		write_reg(REG_RECORD_LENGTH, 8191);
		write_reg(REG_GATE_LENGTH, 1024);
		write_reg(REG_EVENT_COUNT, 2047);
		begin_phase(IDLE_SENDER);
		offer_random(60);
		drain_and_pause();
		write_reg(REG_RECORD_LENGTH, 2);
		begin_phase(IDLE_SINK);
		offer_random(40);
		drain_and_pause();
		write_reg(REG_EVENT_COUNT, 4);
		begin_phase(IDLE_NONE);
		offer_random(6);
		drain_and_pause();

		// long sink hold-off with one-beat records: record queue fills, input stalls
		write_reg(REG_RECORD_LENGTH, 1);
		write_reg(REG_GATE_LENGTH, 1);
		write_reg(REG_EVENT_COUNT, 6);
		begin_phase(IDLE_NONE);
		hold_start = 1'b1;
		offer_random(150);
		@(negedge clk);
		hold_start = 1'b0;
		drain_and_pause();

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			random_settings();
			begin_phase(idle_mode_t'(k % 4));
			offer_random(PHASE_ITEMS);
			drain_and_pause();
		end

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/gwss_pkg.sv
rtl/core/gwss_in_if.sv
rtl/core/gwss_out_if.sv
rtl/core/gwss_front.sv
rtl/core/gwss_fifo.sv
rtl/core/gwss_div.sv
rtl/core/gwss_sqrt.sv
rtl/core/gwss_back.sv
rtl/core/gated_window_sum_statistics.sv
verif/testbench.sv
